// ===== src/wpps_pkg.sv =====
// Package for the wheel position PID settle unit: widths, register codes,
// reset values, shared types and the elaboration-time tanh table function.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package wpps_pkg;

    // Field and state widths
    localparam int unsigned POS_W      = 24;
    localparam int unsigned ERR_W      = 25;
    localparam int unsigned DIFF_W     = 26;
    localparam int unsigned INTEG_W    = 40;
    localparam int unsigned CNT_W      = 16;
    localparam int unsigned GAIN_W     = 24;
    localparam int unsigned BAND_W     = 16;
    localparam int unsigned DRIVE_W    = 9;
    localparam int unsigned MAG_W      = 8;
    localparam int unsigned CFG_IDX_W  = 3;
    localparam int unsigned CFG_DATA_W = 24;

    // Default structural sizes
    localparam int unsigned DEF_CHANNELS     = 2;
    localparam int unsigned DEF_TANH_ENTRIES = 256;
    localparam int unsigned QUEUE_DEPTH      = 4;

    // Register reset values
    localparam logic [GAIN_W-1:0] KP_RESET    = 24'd39322;
    localparam logic [GAIN_W-1:0] KI_RESET    = 24'd0;
    localparam logic [GAIN_W-1:0] KD_RESET    = 24'd0;
    localparam logic [BAND_W-1:0] BAND_RESET  = 16'd45;
    localparam logic [CNT_W-1:0]  LIMIT_RESET = 16'd30;

    // Drive mapping constants: |u| range 400 in Q16 is 25 * 2^20
    localparam int unsigned DRIVE_MAX   = 255;
    localparam longint unsigned TERM_CAP = 64'd1 << 50;
    localparam int unsigned U_LIMIT     = 400 << 16;
    localparam int unsigned U_HALF      = 200 << 16;
    localparam int unsigned U_SHIFT     = 20;
    localparam int unsigned U_DIV       = 25;
    localparam int unsigned RECIP_SHIFT = 24;
    localparam int unsigned DIV_RECIP   = ((1 << RECIP_SHIFT) + U_DIV - 1) / U_DIV;
    localparam int unsigned RECIP_W     = 20;

    // Register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_KP    = 3'd0,
        REG_KI    = 3'd1,
        REG_KD    = 3'd2,
        REG_BAND  = 3'd3,
        REG_LIMIT = 3'd4
    } t_reg_idx;

    // Configuration register set
    typedef struct packed {
        logic [GAIN_W-1:0] kp;
        logic [GAIN_W-1:0] ki;
        logic [GAIN_W-1:0] kd;
        logic [BAND_W-1:0] band;
        logic [CNT_W-1:0]  limit;
    } t_cfg;

    // Classified item passed from front to back
    typedef struct packed {
        logic                    kind;
        logic                    channel;
        logic signed [ERR_W-1:0] err;
        logic                    near;
    } t_work;

    // Shift-subtract divide, used only while building constants
    function automatic logic [63:0] udiv64(logic [63:0] a, logic [63:0] b);
        logic [63:0] q;
        logic [63:0] r;
        q = '0;
        r = '0;
        for (int k = 63; k >= 0; k--) begin
            r = {r[62:0], a[k]};
            if (r >= b) begin
                r    = r - b;
                q[k] = 1'b1;
            end
        end
        return q;
    endfunction

    // Entry i: round(255 * tanh(4 * i / n)) computed in Q30
    function automatic logic [MAG_W-1:0] tanh_entry(int unsigned i, int unsigned n);
        logic [63:0] q_one;
        logic [63:0] x;
        logic [63:0] h;
        logic [63:0] term;
        logic [63:0] d;
        logic [63:0] num;
        logic [63:0] den;
        logic [63:0] mag;
        longint      s;
        q_one = 64'd1 << 30;
        x     = udiv64((64'(i) * 64'd8) << 30, 64'(n));
        h     = x >> 4;
        term  = q_one;
        s     = longint'(q_one);
        for (int k = 1; k <= 16; k++) begin
            term = udiv64((term * h) >> 30, 64'(k));
            if ((k % 2) == 1) s = s - longint'(term);
            else              s = s + longint'(term);
        end
        if (s < 0) s = 0;
        d = 64'(s);
        if (d > q_one) d = q_one;
        for (int k = 0; k < 4; k++) begin
            d = (d * d + (64'd1 << 29)) >> 30;
            if (d > q_one) d = q_one;
        end
        num = 64'd511 * q_one - 64'd509 * d;
        den = 64'd2 * (q_one + d);
        mag = udiv64(num, den);
        if (mag > 64'(DRIVE_MAX)) mag = 64'(DRIVE_MAX);
        return mag[MAG_W-1:0];
    endfunction

endpackage

`default_nettype wire

// ===== src/wpps_in_if.sv =====
// Input channel of the wheel position PID settle unit: valid/ready plus the
// step item payload. Depends on wpps_pkg for field widths.
`timescale 1ns / 1ps
`default_nettype none

interface wpps_in_if;
    logic                                 valid;
    logic                                 ready;
    logic                                 kind;
    logic                                 channel;
    logic signed [wpps_pkg::POS_W-1:0]    target;
    logic signed [wpps_pkg::POS_W-1:0]    measured_position;

    modport source (output valid, kind, channel, target, measured_position, input ready);
    modport sink   (input valid, kind, channel, target, measured_position, output ready);
endinterface

`default_nettype wire

// ===== src/wpps_out_if.sv =====
// Result channel of the wheel position PID settle unit: valid/ready plus the
// drive result payload. Depends on wpps_pkg for field widths.
`timescale 1ns / 1ps
`default_nettype none

interface wpps_out_if;
    logic                                 valid;
    logic                                 ready;
    logic signed [wpps_pkg::DRIVE_W-1:0]  drive;
    logic                                 at_goal;
    logic                                 out_channel;

    modport source (output valid, drive, at_goal, out_channel, input ready);
    modport sink   (input valid, drive, at_goal, out_channel, output ready);
endinterface

`default_nettype wire

// ===== src/wpps_front.sv =====
// Front end: takes step items, forms the channel error and the near-goal
// flag, and pushes the classified item into the queue. Uses wpps_pkg.
`timescale 1ns / 1ps
`default_nettype none

module wpps_front (
    wpps_in_if.sink                    i_in,
    input  logic [wpps_pkg::BAND_W-1:0] i_band,
    input  logic                        i_q_full,
    output logic                        o_push,
    output wpps_pkg::t_work             o_work
);
    import wpps_pkg::*;

    logic signed [ERR_W-1:0] w_diff;
    logic signed [ERR_W-1:0] w_err;
    logic        [ERR_W-1:0] w_abs;

    // Accept whenever the queue has room
    assign i_in.ready = !i_q_full;
    assign o_push     = i_in.valid && !i_q_full;

    // Error is target minus measured, negated on the right wheel
    assign w_diff = {i_in.target[POS_W-1], i_in.target}
                  - {i_in.measured_position[POS_W-1], i_in.measured_position};
    assign w_err  = i_in.channel ? -w_diff : w_diff;
    assign w_abs  = w_err[ERR_W-1] ? (~w_err + ERR_W'(1)) : w_err;

    // Pack the classified item
    always_comb begin
        o_work.kind    = i_in.kind;
        o_work.channel = i_in.channel;
        o_work.err     = w_err;
        o_work.near    = w_abs < ERR_W'(i_band);
    end

endmodule

`default_nettype wire

// ===== src/wpps_queue.sv =====
// Short queue between front and back so each side can stall on its own.
// Holds classified items of type wpps_pkg::t_work.
`timescale 1ns / 1ps
`default_nettype none

module wpps_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  wpps_pkg::t_work i_data,
    output logic            o_full,
    output logic            o_valid,
    input  logic            i_pop,
    output wpps_pkg::t_work o_data
);
    import wpps_pkg::*;

    localparam int unsigned DEPTH = QUEUE_DEPTH;
    localparam int unsigned PTR_W = $clog2(DEPTH);
    localparam int unsigned CNT_Q = $clog2(DEPTH + 1);

    t_work              r_mem [DEPTH];
    logic [PTR_W-1:0]   r_wptr;
    logic [PTR_W-1:0]   r_rptr;
    logic [CNT_Q-1:0]   r_count;
    logic [CNT_Q-1:0]   n_count;

    assign o_full  = (r_count == CNT_Q'(DEPTH));
    assign o_valid = (r_count != '0);
    assign o_data  = r_mem[r_rptr];

    // Track fill level
    always_comb begin
        n_count = r_count;
        if (i_push && !i_pop) n_count = r_count + CNT_Q'(1);
        if (!i_push && i_pop) n_count = r_count - CNT_Q'(1);
    end

    // Advance pointers and count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            r_count <= n_count;
            if (i_push) begin
                r_wptr <= (r_wptr == PTR_W'(DEPTH - 1)) ? '0 : r_wptr + PTR_W'(1);
            end
            if (i_pop) begin
                r_rptr <= (r_rptr == PTR_W'(DEPTH - 1)) ? '0 : r_rptr + PTR_W'(1);
            end
        end
    end

    // Store pushed items
    always_ff @(posedge i_clk) begin
        if (i_push) r_mem[r_wptr] <= i_data;
    end

endmodule

`default_nettype wire

// ===== src/wpps_back.sv =====
// Back end: per-channel state update, gain multiplies, term sum and tanh
// table lookup in an eight-stage pipeline. Uses wpps_pkg and wpps_out_if.
`timescale 1ns / 1ps
`default_nettype none

module wpps_back #(
    parameter int unsigned CHANNELS     = wpps_pkg::DEF_CHANNELS,
    parameter int unsigned TANH_ENTRIES = wpps_pkg::DEF_TANH_ENTRIES
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  wpps_pkg::t_cfg  i_cfg,
    input  logic            i_q_valid,
    input  wpps_pkg::t_work i_q_data,
    output logic            o_pop,
    wpps_out_if.source      o_out
);
    import wpps_pkg::*;

    localparam int unsigned STAGES = 8;
    localparam int unsigned CH_W   = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int unsigned IDX_W  = $clog2(TANH_ENTRIES);
    localparam int unsigned NUM_W  = 26 + $clog2(TANH_ENTRIES + 1);
    localparam int unsigned Q_W    = NUM_W - U_SHIFT;
    localparam int unsigned PROD_W = Q_W + RECIP_W;
    localparam int unsigned PE_W   = ERR_W + GAIN_W;
    localparam int unsigned PD_W   = DIFF_W + GAIN_W;
    localparam int unsigned HALF_I = INTEG_W / 2;
    localparam int unsigned PI_W   = HALF_I + GAIN_W;
    localparam int unsigned CAP_W  = 51;
    localparam int unsigned TERM_W = 52;
    localparam int unsigned U_W    = 54;
    localparam int unsigned ULO_W  = 25;

    // Constant tanh table
    logic [MAG_W-1:0] w_rom [TANH_ENTRIES];
    for (genvar g = 0; g < TANH_ENTRIES; g++) begin : g_rom
        localparam logic [MAG_W-1:0] ENTRY = tanh_entry(g, TANH_ENTRIES);
        assign w_rom[g] = ENTRY;
    end

    // Pipeline flow control
    logic [STAGES-1:0] r_v;
    logic [STAGES-1:0] w_ld;

    always_comb begin
        w_ld[STAGES-1] = !r_v[STAGES-1] || o_out.ready;
        for (int k = STAGES - 2; k >= 0; k--) begin
            w_ld[k] = !r_v[k] || w_ld[k+1];
        end
    end

    assign o_pop = i_q_valid && w_ld[0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            if (w_ld[0]) r_v[0] <= i_q_valid;
            for (int k = 1; k < STAGES; k++) begin
                if (w_ld[k]) r_v[k] <= r_v[k-1];
            end
        end
    end

    // Stage 0: per-channel state read, update and write back
    logic signed [ERR_W-1:0]   r_prev  [CHANNELS];
    logic signed [INTEG_W-1:0] r_integ [CHANNELS];
    logic        [CNT_W-1:0]   r_cnt   [CHANNELS];

    logic [CH_W-1:0]             w_c;
    logic signed [ERR_W-1:0]     w_prev;
    logic signed [INTEG_W-1:0]   w_integ;
    logic        [CNT_W-1:0]     w_cnt;
    logic signed [DIFF_W-1:0]    w_d;
    logic signed [INTEG_W:0]     w_sum;
    logic signed [INTEG_W-1:0]   w_acc;
    logic        [CNT_W-1:0]     n_cnt;

    assign w_c     = (CHANNELS > 1) ? CH_W'(i_q_data.channel) : '0;
    assign w_prev  = r_prev[w_c];
    assign w_integ = r_integ[w_c];
    assign w_cnt   = r_cnt[w_c];
    assign w_d     = {i_q_data.err[ERR_W-1], i_q_data.err} - {w_prev[ERR_W-1], w_prev};
    assign w_sum   = {w_integ[INTEG_W-1], w_integ}
                   + {{(INTEG_W + 1 - ERR_W){i_q_data.err[ERR_W-1]}}, i_q_data.err};

    // Saturate the integral on overflow of the top bit
    always_comb begin
        w_acc = w_sum[INTEG_W-1:0];
        if (w_sum[INTEG_W] != w_sum[INTEG_W-1]) begin
            w_acc = w_sum[INTEG_W] ? {1'b1, {(INTEG_W - 1){1'b0}}}
                                   : {1'b0, {(INTEG_W - 1){1'b1}}};
        end
        if (!i_q_data.near)      n_cnt = '0;
        else if (w_cnt == '1)    n_cnt = w_cnt;
        else                     n_cnt = w_cnt + CNT_W'(1);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < CHANNELS; k++) begin
                r_prev[k]  <= '0;
                r_integ[k] <= '0;
                r_cnt[k]   <= '0;
            end
        end else if (o_pop) begin
            if (i_q_data.kind) begin
                for (int k = 0; k < CHANNELS; k++) r_integ[k] <= '0;
            end else begin
                r_prev[w_c]  <= i_q_data.err;
                r_integ[w_c] <= w_acc;
                r_cnt[w_c]   <= n_cnt;
            end
        end
    end

    logic                       r0_kind;
    logic                       r0_chan;
    logic signed [ERR_W-1:0]    r0_e;
    logic signed [DIFF_W-1:0]   r0_d;
    logic signed [INTEG_W-1:0]  r0_acc;
    logic        [CNT_W-1:0]    r0_cnt;

    always_ff @(posedge i_clk) begin
        if (w_ld[0]) begin
            r0_kind <= i_q_data.kind;
            r0_chan <= i_q_data.channel;
            r0_e    <= i_q_data.err;
            r0_d    <= w_d;
            r0_acc  <= w_acc;
            r0_cnt  <= n_cnt;
        end
    end

    // Stage 1: magnitudes and gain multiplies
    logic [ERR_W-1:0]   w_ae;
    logic [DIFF_W-1:0]  w_ad;
    logic [INTEG_W-1:0] w_ai;

    assign w_ae = r0_e[ERR_W-1]     ? (~r0_e + ERR_W'(1))     : r0_e;
    assign w_ad = r0_d[DIFF_W-1]    ? (~r0_d + DIFF_W'(1))    : r0_d;
    assign w_ai = r0_acc[INTEG_W-1] ? (~r0_acc + INTEG_W'(1)) : r0_acc;

    logic              r1_kind, r1_chan, r1_within;
    logic              r1_ne, r1_nd, r1_ni;
    logic [PE_W-1:0]   r1_pe;
    logic [PD_W-1:0]   r1_pd;
    logic [PI_W-1:0]   r1_pil;
    logic [PI_W-1:0]   r1_pih;

    always_ff @(posedge i_clk) begin
        if (w_ld[1]) begin
            r1_kind   <= r0_kind;
            r1_chan   <= r0_chan;
            r1_within <= r0_cnt > i_cfg.limit;
            r1_ne     <= r0_e[ERR_W-1];
            r1_nd     <= r0_d[DIFF_W-1];
            r1_ni     <= r0_acc[INTEG_W-1];
            r1_pe     <= PE_W'(w_ae) * PE_W'(i_cfg.kp);
            r1_pd     <= PD_W'(w_ad) * PD_W'(i_cfg.kd);
            r1_pil    <= PI_W'(w_ai[HALF_I-1:0]) * PI_W'(i_cfg.ki);
            r1_pih    <= PI_W'(w_ai[INTEG_W-1:HALF_I]) * PI_W'(i_cfg.ki);
        end
    end

    // Stage 2: join integral partial products, clamp, sign P and D terms
    logic [63:0] w_pi_full;
    assign w_pi_full = {r1_pih, {HALF_I{1'b0}}} + 64'(r1_pil);

    logic                      r2_kind, r2_chan, r2_within, r2_ni;
    logic [CAP_W-1:0]          r2_pi;
    logic signed [TERM_W-1:0]  r2_te;
    logic signed [TERM_W-1:0]  r2_td;

    always_ff @(posedge i_clk) begin
        if (w_ld[2]) begin
            r2_kind   <= r1_kind;
            r2_chan   <= r1_chan;
            r2_within <= r1_within;
            r2_ni     <= r1_ni;
            r2_pi     <= (w_pi_full > TERM_CAP) ? CAP_W'(TERM_CAP) : w_pi_full[CAP_W-1:0];
            r2_te     <= r1_ne ? -$signed(TERM_W'(r1_pe)) : $signed(TERM_W'(r1_pe));
            r2_td     <= r1_nd ? -$signed(TERM_W'(r1_pd)) : $signed(TERM_W'(r1_pd));
        end
    end

    // Stage 3: sum of the three terms
    logic signed [TERM_W-1:0] w_ti;
    assign w_ti = r2_ni ? -$signed({1'b0, r2_pi}) : $signed({1'b0, r2_pi});

    logic                  r3_kind, r3_chan, r3_within;
    logic signed [U_W-1:0] r3_u;

    always_ff @(posedge i_clk) begin
        if (w_ld[3]) begin
            r3_kind   <= r2_kind;
            r3_chan   <= r2_chan;
            r3_within <= r2_within;
            r3_u      <= U_W'(r2_te) + U_W'(r2_td) + U_W'(w_ti);
        end
    end

    // Stage 4: magnitude of u and range check
    logic [U_W-1:0] w_um;
    assign w_um = r3_u[U_W-1] ? (~r3_u + U_W'(1)) : r3_u;

    logic               r4_kind, r4_chan, r4_within, r4_neg, r4_lim;
    logic [ULO_W-1:0]   r4_ulo;

    always_ff @(posedge i_clk) begin
        if (w_ld[4]) begin
            r4_kind   <= r3_kind;
            r4_chan   <= r3_chan;
            r4_within <= r3_within;
            r4_neg    <= r3_u[U_W-1];
            r4_lim    <= w_um < U_W'(U_LIMIT);
            r4_ulo    <= w_um[ULO_W-1:0];
        end
    end

    // Stage 5: scale by table size, add half step, drop low bits
    logic [NUM_W-1:0] w_num;
    assign w_num = NUM_W'(r4_ulo) * NUM_W'(TANH_ENTRIES) + NUM_W'(U_HALF);

    logic             r5_kind, r5_chan, r5_within, r5_neg, r5_lim;
    logic [Q_W-1:0]   r5_q;

    always_ff @(posedge i_clk) begin
        if (w_ld[5]) begin
            r5_kind   <= r4_kind;
            r5_chan   <= r4_chan;
            r5_within <= r4_within;
            r5_neg    <= r4_neg;
            r5_lim    <= r4_lim;
            r5_q      <= w_num[NUM_W-1:U_SHIFT];
        end
    end

    // Stage 6: divide by the remaining factor through its reciprocal
    logic [PROD_W-1:0] w_prod;
    assign w_prod = PROD_W'(r5_q) * PROD_W'(DIV_RECIP);

    logic             r6_kind, r6_chan, r6_within, r6_neg, r6_lim;
    logic [IDX_W:0]   r6_idx;

    always_ff @(posedge i_clk) begin
        if (w_ld[6]) begin
            r6_kind   <= r5_kind;
            r6_chan   <= r5_chan;
            r6_within <= r5_within;
            r6_neg    <= r5_neg;
            r6_lim    <= r5_lim;
            r6_idx    <= w_prod[RECIP_SHIFT +: IDX_W + 1];
        end
    end

    // Stage 7: table read, saturation and sign
    logic [MAG_W-1:0]          w_mag;
    logic signed [DRIVE_W-1:0] w_drive;

    always_comb begin
        if (!r6_lim || (r6_idx >= (IDX_W + 1)'(TANH_ENTRIES))) w_mag = MAG_W'(DRIVE_MAX);
        else                                                    w_mag = w_rom[r6_idx[IDX_W-1:0]];
        w_drive = r6_neg ? -$signed({1'b0, w_mag}) : $signed({1'b0, w_mag});
    end

    logic signed [DRIVE_W-1:0] r7_drive;
    logic                      r7_within;
    logic                      r7_chan;

    always_ff @(posedge i_clk) begin
        if (w_ld[7]) begin
            r7_drive  <= r6_kind ? '0 : w_drive;
            r7_within <= r6_kind ? 1'b0 : r6_within;
            r7_chan   <= r6_chan;
        end
    end

    // Drive the result channel
    assign o_out.valid       = r_v[STAGES-1];
    assign o_out.drive       = r7_drive;
    assign o_out.at_goal     = r7_within;
    assign o_out.out_channel = r7_chan;

endmodule

`default_nettype wire

// ===== src/wheel_position_pid_settle_unit.sv =====
// Wheel position PID settle unit. Throughput: one item per cycle while the
// result side takes results, set by the per-channel state update at the head
// of the back pipeline.
// Reset clears the configuration to defaults, all per-channel state, the
// queue and the pipeline; no clearing pass is needed.
// Depends on wpps_pkg, wpps_in_if, wpps_out_if, wpps_front, wpps_queue, wpps_back.
`timescale 1ns / 1ps
`default_nettype none

module wheel_position_pid_settle_unit #(
    parameter int unsigned CHANNELS     = wpps_pkg::DEF_CHANNELS,
    parameter int unsigned TANH_ENTRIES = wpps_pkg::DEF_TANH_ENTRIES
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [wpps_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [wpps_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    wpps_in_if.sink                           i_in,
    wpps_out_if.source                        o_out
);
    import wpps_pkg::*;

    t_cfg  r_cfg;
    t_cfg  n_cfg;
    t_work w_work;
    t_work w_q_data;
    logic  w_push;
    logic  w_full;
    logic  w_q_valid;
    logic  w_pop;

    // Decode configuration writes
    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_we) begin
            case (i_cfg_index)
                REG_KP:    n_cfg.kp    = i_cfg_data;
                REG_KI:    n_cfg.ki    = i_cfg_data;
                REG_KD:    n_cfg.kd    = i_cfg_data;
                REG_BAND:  n_cfg.band  = i_cfg_data[BAND_W-1:0];
                REG_LIMIT: n_cfg.limit = i_cfg_data[CNT_W-1:0];
                default:   n_cfg       = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.kp    <= KP_RESET;
            r_cfg.ki    <= KI_RESET;
            r_cfg.kd    <= KD_RESET;
            r_cfg.band  <= BAND_RESET;
            r_cfg.limit <= LIMIT_RESET;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    // Accept and classify
    wpps_front u_front (
        .i_in     (i_in),
        .i_band   (r_cfg.band),
        .i_q_full (w_full),
        .o_push   (w_push),
        .o_work   (w_work)
    );

    // Decouple front and back
    wpps_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_data  (w_work),
        .o_full  (w_full),
        .o_valid (w_q_valid),
        .i_pop   (w_pop),
        .o_data  (w_q_data)
    );

    // Execute
    wpps_back #(
        .CHANNELS     (CHANNELS),
        .TANH_ENTRIES (TANH_ENTRIES)
    ) u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg     (r_cfg),
        .i_q_valid (w_q_valid),
        .i_q_data  (w_q_data),
        .o_pop     (w_pop),
        .o_out     (o_out)
    );

endmodule

`default_nettype wire

// ===== sim/wpps_drive_checker.sv =====
// Result checker for the wheel position PID settle unit: watches the step and
// result channels, predicts each drive result and compares it field by field.
// Depends on wpps_pkg, wpps_in_if and wpps_out_if.
`timescale 1ns / 1ps

module wpps_drive_checker #(
    parameter logic CLEAR_KIND = 1'b1
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [wpps_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [wpps_pkg::CFG_DATA_W-1:0] i_cfg_data,
    wpps_in_if                              i_step,
    wpps_out_if                             i_result,
    output int                              o_fail_count,
    output int                              o_outstanding
);
    import wpps_pkg::*;

    typedef longint unsigned u64;

    localparam int     CHAN_COUNT   = 2;
    localparam int     LUT_SIZE     = 256;
    localparam u64     Q30_ONE      = u64'(1) << 30;
    localparam u64     PRODUCT_CAP  = u64'(1) << 50;
    localparam u64     FULL_SCALE   = u64'(400) << 16;
    localparam u64     HALF_STEP    = u64'(200) << 16;
    localparam longint INTEG_TOP    = (longint'(1) <<< 39) - 1;
    localparam longint INTEG_BOTTOM = -INTEG_TOP - 1;
    localparam u64     DRIVE_PEAK   = 255;

    localparam logic [GAIN_W-1:0] PROP_DEFAULT  = 24'd39322;
    localparam logic [BAND_W-1:0] BAND_DEFAULT  = 16'd45;
    localparam logic [CNT_W-1:0]  LIMIT_DEFAULT = 16'd30;
    localparam logic [CNT_W-1:0]  COUNT_FULL    = '1;

    typedef struct packed {
        logic signed [DRIVE_W-1:0] drive;
        logic                      at_goal;
        logic                      out_channel;
    } t_drive_result;

    // Register shadows
    logic [GAIN_W-1:0] prop_gain;
    logic [GAIN_W-1:0] integ_gain;
    logic [GAIN_W-1:0] deriv_gain;
    logic [BAND_W-1:0] near_band;
    logic [CNT_W-1:0]  goal_limit;

    // Per-wheel loop state
    logic signed [ERR_W-1:0]   last_error [CHAN_COUNT];
    logic signed [INTEG_W-1:0] error_sum  [CHAN_COUNT];
    logic [CNT_W-1:0]          near_run   [CHAN_COUNT];

    logic [MAG_W-1:0] tanh_lut [LUT_SIZE];
    t_drive_result    drive_forecast [$];

    // Duty level for one table slot: 255*tanh(4*slot/LUT_SIZE), worked in Q30
    function automatic logic [MAG_W-1:0] tanh_level(int unsigned slot);
        u64     h;
        u64     term;
        u64     d;
        u64     num;
        u64     den;
        u64     level;
        longint series;
        h      = (((u64'(slot) * 8) << 30) / LUT_SIZE) >> 4;
        term   = Q30_ONE;
        series = longint'(Q30_ONE);
        // exp(-h) by a truncated series, then raise to the 16th power
        for (int k = 1; k <= 16; k++) begin
            term = ((term * h) >> 30) / u64'(k);
            if (k % 2 == 1) series = series - longint'(term);
            else            series = series + longint'(term);
        end
        if (series < 0) series = 0;
        d = u64'(series);
        if (d > Q30_ONE) d = Q30_ONE;
        for (int k = 0; k < 4; k++) begin
            d = (d * d + (u64'(1) << 29)) >> 30;
            if (d > Q30_ONE) d = Q30_ONE;
        end
        num   = 511 * Q30_ONE - 509 * d;
        den   = 2 * (Q30_ONE + d);
        level = num / den;
        if (level > DRIVE_PEAK) level = DRIVE_PEAK;
        return level[MAG_W-1:0];
    endfunction

    // Gain times signed value in Q16, magnitude clamped
    function automatic longint weighted(logic [GAIN_W-1:0] gain, longint value);
        u64 prod;
        prod = ((value < 0) ? u64'(-value) : u64'(value)) * u64'(gain);
        if (prod > PRODUCT_CAP) prod = PRODUCT_CAP;
        return (value < 0) ? -longint'(prod) : longint'(prod);
    endfunction

    // Advance the loop state by one step item and return its drive result
    function automatic t_drive_result forecast_step(logic kind, logic chan,
            logic signed [POS_W-1:0] tgt, logic signed [POS_W-1:0] meas);
        t_drive_result res;
        int            slot;
        longint        err;
        longint        delta;
        longint        total;
        longint        u;
        u64            mag;
        u64            level;
        u64            idx;
        res.drive       = '0;
        res.at_goal     = 1'b0;
        res.out_channel = chan;
        slot            = int'(chan) % CHAN_COUNT;
        if (kind == CLEAR_KIND) begin
            for (int k = 0; k < CHAN_COUNT; k++) error_sum[k] = '0;
            return res;
        end

        err = longint'(tgt) - longint'(meas);
        if (chan) err = -err;
        delta = err - longint'(last_error[slot]);
        last_error[slot] = ERR_W'(err);

        // Saturate the running sum
        total = longint'(error_sum[slot]) + err;
        if (total > INTEG_TOP)    total = INTEG_TOP;
        if (total < INTEG_BOTTOM) total = INTEG_BOTTOM;
        error_sum[slot] = INTEG_W'(total);

        // Map |u| through the tanh table, keep the sign
        u = weighted(prop_gain, err) + weighted(deriv_gain, delta)
            + weighted(integ_gain, total);
        mag   = (u < 0) ? u64'(-u) : u64'(u);
        level = DRIVE_PEAK;
        if (mag < FULL_SCALE) begin
            idx = (mag * LUT_SIZE + HALF_STEP) / FULL_SCALE;
            if (idx < LUT_SIZE) level = u64'(tanh_lut[idx]);
        end
        res.drive = DRIVE_W'((u < 0) ? -longint'(level) : longint'(level));

        // Count consecutive near-goal steps, holding at full scale
        mag = (err < 0) ? u64'(-err) : u64'(err);
        if (mag < u64'(near_band)) begin
            if (near_run[slot] != COUNT_FULL) near_run[slot] = near_run[slot] + 1'b1;
        end else begin
            near_run[slot] = '0;
        end
        res.at_goal = (near_run[slot] > goal_limit);
        return res;
    endfunction

    initial begin
        for (int i = 0; i < LUT_SIZE; i++) tanh_lut[i] = tanh_level(i);
    end

    // Track registers, check result transfers, queue forecasts for step transfers
    always @(posedge i_clk) begin : track
        t_drive_result seen;
        t_drive_result want;
        if (!i_rst_n) begin
            prop_gain    = PROP_DEFAULT;
            integ_gain   = '0;
            deriv_gain   = '0;
            near_band    = BAND_DEFAULT;
            goal_limit   = LIMIT_DEFAULT;
            for (int k = 0; k < CHAN_COUNT; k++) begin
                last_error[k] = '0;
                error_sum[k]  = '0;
                near_run[k]   = '0;
            end
            drive_forecast.delete();
            o_fail_count = 0;
        end else begin
            if (i_result.valid && i_result.ready) begin
                seen.drive       = i_result.drive;
                seen.at_goal     = i_result.at_goal;
                seen.out_channel = i_result.out_channel;
                if (drive_forecast.size() == 0) begin
                    $display("%0t: result transfer with none expected: drive %0d goal %0b ch %0b",
                             $time, seen.drive, seen.at_goal, seen.out_channel);
                    o_fail_count = o_fail_count + 1;
                end else begin
                    want = drive_forecast.pop_front();
                    if (seen.drive !== want.drive) begin
                        $display("%0t: drive expected %0d, actual %0d",
                                 $time, want.drive, seen.drive);
                        o_fail_count = o_fail_count + 1;
                    end
                    if (seen.at_goal !== want.at_goal) begin
                        $display("%0t: at_goal expected %0b, actual %0b",
                                 $time, want.at_goal, seen.at_goal);
                        o_fail_count = o_fail_count + 1;
                    end
                    if (seen.out_channel !== want.out_channel) begin
                        $display("%0t: out_channel expected %0b, actual %0b",
                                 $time, want.out_channel, seen.out_channel);
                        o_fail_count = o_fail_count + 1;
                    end
                end
            end

            if (i_cfg_we) begin
                case (i_cfg_index)
                    REG_KP:    prop_gain  = i_cfg_data[GAIN_W-1:0];
                    REG_KI:    integ_gain = i_cfg_data[GAIN_W-1:0];
                    REG_KD:    deriv_gain = i_cfg_data[GAIN_W-1:0];
                    REG_BAND:  near_band  = i_cfg_data[BAND_W-1:0];
                    REG_LIMIT: goal_limit = i_cfg_data[CNT_W-1:0];
                    default: ;
                endcase
            end

            if (i_step.valid && i_step.ready) begin
                drive_forecast.push_back(forecast_step(i_step.kind, i_step.channel,
                                                       i_step.target,
                                                       i_step.measured_position));
            end
        end
        o_outstanding = drive_forecast.size();
    end

endmodule

// ===== sim/tb.sv =====
// Top of the wheel position PID settle unit testbench: clock, reset, register
// programming, step stimulus and result back-pressure, final verdict.
// Depends on wpps_pkg, wpps_in_if, wpps_out_if, wpps_drive_checker and the unit.
`timescale 1ns / 1ps

module tb;
    import wpps_pkg::*;

    localparam time         HALF_PERIOD    = 4ns;
    localparam int          RESULT_LATENCY = 8;
    localparam int unsigned CYCLE_LIMIT    = 1_000_000;
    localparam int          MAX_WAIT       = 11;

    localparam logic KIND_STEP  = 1'b0;
    localparam logic KIND_CLEAR = 1'b1;

    localparam logic [CFG_IDX_W-1:0]     REG_UNMAPPED = 3'd7;
    localparam logic signed [POS_W-1:0] POS_MAX      = 24'sh7FFFFF;
    localparam logic signed [POS_W-1:0] POS_MIN      = 24'sh800000;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    int          fail_count;
    int          outstanding;
    int unsigned cycle_count = 0;
    int unsigned cur_band;
    bit          burst_mode;
    bit          feed_calm;
    bit          sink_calm;

    wpps_in_if  step_ch ();
    wpps_out_if result_ch ();

    wheel_position_pid_settle_unit dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data),
        .i_in        (step_ch),
        .o_out       (result_ch)
    );

    wpps_drive_checker #(
        .CLEAR_KIND (KIND_CLEAR)
    ) checker_inst (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (cfg_we),
        .i_cfg_index   (cfg_index),
        .i_cfg_data    (cfg_data),
        .i_step        (step_ch),
        .i_result      (result_ch),
        .o_fail_count  (fail_count),
        .o_outstanding (outstanding)
    );

    initial i_clk = 1'b0;
    always #(HALF_PERIOD) i_clk = ~i_clk;

    // Abort a hung run
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // Clamp a position to the 24-bit encoder range
    function automatic logic signed [POS_W-1:0] fit_pos(longint v);
        if (v > longint'(POS_MAX)) return POS_MAX;
        if (v < longint'(POS_MIN)) return POS_MIN;
        return POS_W'(v);
    endfunction

    // Drive one step item and hold it until its transfer
    task automatic send_step(logic kind, logic chan, logic signed [POS_W-1:0] tgt,
                             logic signed [POS_W-1:0] meas);
        int unsigned gap;
        gap = (burst_mode || feed_calm) ? 0 : $urandom_range(0, MAX_WAIT);
        if ($urandom_range(0, 39) == 0) feed_calm = !feed_calm;
        repeat (gap) begin
            @(negedge i_clk);
            step_ch.valid <= 1'b0;
        end
        @(negedge i_clk);
        step_ch.valid             <= 1'b1;
        step_ch.kind              <= kind;
        step_ch.channel           <= chan;
        step_ch.target            <= tgt;
        step_ch.measured_position <= meas;
        do @(posedge i_clk); while (!step_ch.ready);
    endtask

    task automatic put_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
        @(negedge i_clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
    endtask

    // Program all registers, plus one write to an unmapped index
    task automatic program_regs(logic [GAIN_W-1:0] kp, logic [GAIN_W-1:0] ki,
                                logic [GAIN_W-1:0] kd, logic [BAND_W-1:0] band,
                                logic [CNT_W-1:0] limit);
        put_reg(REG_UNMAPPED, CFG_DATA_W'($urandom));
        put_reg(REG_KP, kp);
        put_reg(REG_KI, ki);
        put_reg(REG_KD, kd);
        put_reg(REG_BAND, CFG_DATA_W'(band));
        put_reg(REG_LIMIT, CFG_DATA_W'(limit));
        @(negedge i_clk);
        cfg_we   <= 1'b0;
        cur_band = band;
    endtask

    // Drop valid, wait for every expected result, then let the pipeline empty
    task automatic drain_results();
        @(negedge i_clk);
        step_ch.valid <= 1'b0;
        while (outstanding != 0) @(negedge i_clk);
        repeat (RESULT_LATENCY) @(negedge i_clk);
    endtask

    // Settling runs: error decays toward the goal with jitter, mixed with
    // clear items and unrelated noise steps
    task automatic random_steps(int count);
        int                      sent;
        int                      run_len;
        int unsigned             roll;
        longint                  jit;
        longint                  tgt;
        longint                  err;
        logic                    chan;
        logic signed [POS_W-1:0] wide_pos;
        sent = 0;
        jit  = (cur_band < 3) ? 1 : ((cur_band > 12000) ? 4000 : cur_band / 3);
        while (sent < count) begin
            chan = 1'($urandom);
            if ($urandom_range(0, 3) == 0) begin
                wide_pos = POS_W'($urandom);
                tgt      = longint'(wide_pos);
            end else begin
                tgt = longint'($urandom_range(0, 10000)) - 5000;
            end
            err     = longint'($urandom_range(0, 4000)) - 2000;
            run_len = $urandom_range(4, 80);
            for (int k = 0; k < run_len && sent < count; k++) begin
                roll = $urandom_range(0, 99);
                if (roll < 4) begin
                    send_step(KIND_CLEAR, 1'($urandom), POS_W'($urandom), POS_W'($urandom));
                end else if (roll < 12) begin
                    send_step(KIND_STEP, 1'($urandom), POS_W'($urandom), POS_W'($urandom));
                end else begin
                    send_step(KIND_STEP, chan, POS_W'(tgt),
                              fit_pos(chan ? tgt + err : tgt - err));
                    err = (err * 3) / 4 + longint'($urandom_range(0, 2 * jit)) - jit;
                end
                sent++;
            end
        end
    endtask

    // Back-to-back stream: near-goal steps on wheel 0, or widest errors on both wheels
    task automatic hammer(int count, bit near_goal);
        longint tgt;
        longint err;
        for (int k = 0; k < count; k++) begin
            if (near_goal) begin
                tgt = longint'($urandom_range(0, 8388608)) - 4194304;
                err = longint'($urandom_range(0, 2000)) - 1000;
                send_step(KIND_STEP, 1'b0, POS_W'(tgt), fit_pos(tgt - err));
            end else begin
                send_step(KIND_STEP, 1'(k % 2), POS_MAX, POS_MIN);
            end
        end
    endtask

    // Result side back-pressure
    initial begin : result_sink
        int unsigned stall;
        result_ch.ready = 1'b0;
        sink_calm       = 1'b0;
        wait (i_rst_n === 1'b1);
        forever begin
            stall = (burst_mode || sink_calm) ? 0 : $urandom_range(0, MAX_WAIT);
            if ($urandom_range(0, 39) == 0) sink_calm = !sink_calm;
            repeat (stall) begin
                @(negedge i_clk);
                result_ch.ready <= 1'b0;
            end
            @(negedge i_clk);
            result_ch.ready <= 1'b1;
            do @(posedge i_clk); while (!(result_ch.valid && result_ch.ready));
        end
    end

    initial begin
        i_rst_n                   = 1'b0;
        cfg_we                    = 1'b0;
        cfg_index                 = '0;
        cfg_data                  = '0;
        step_ch.valid             = 1'b0;
        step_ch.kind              = KIND_STEP;
        step_ch.channel           = 1'b0;
        step_ch.target            = '0;
        step_ch.measured_position = '0;
        burst_mode                = 1'b0;
        feed_calm                 = 1'b0;
        cur_band                  = 45;
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: clears, widest errors both wheels, band edges, drive saturation edge
        send_step(KIND_CLEAR, 1'b0, POS_MAX, POS_MIN);
        send_step(KIND_STEP, 1'b0, POS_MAX, POS_MIN);
        send_step(KIND_STEP, 1'b0, POS_MIN, POS_MAX);
        send_step(KIND_STEP, 1'b1, POS_MAX, POS_MIN);
        send_step(KIND_STEP, 1'b1, POS_MIN, POS_MAX);
        send_step(KIND_STEP, 1'b0, 24'sd0, 24'sd0);
        send_step(KIND_STEP, 1'b0, 24'sd44, 24'sd0);
        send_step(KIND_STEP, 1'b0, 24'sd0, 24'sd45);
        send_step(KIND_STEP, 1'b1, -24'sd45, 24'sd0);
        send_step(KIND_STEP, 1'b1, 24'sd1, 24'sd45);
        send_step(KIND_STEP, 1'b0, 24'sd666, 24'sd0);
        send_step(KIND_STEP, 1'b0, 24'sd667, 24'sd0);
        send_step(KIND_STEP, 1'b0, 24'sd668, 24'sd0);
        send_step(KIND_STEP, 1'b0, 24'sd0, 24'sd667);
        send_step(KIND_STEP, 1'b0, 24'sd1, 24'sd0);
        send_step(KIND_STEP, 1'b0, -24'sd1, 24'sd0);
        send_step(KIND_STEP, 1'b1, 24'sd0, -24'sd1);
        send_step(KIND_STEP, 1'b1, -24'sd1, -24'sd1);
        send_step(KIND_CLEAR, 1'b1, 24'sd0, 24'sd0);
        send_step(KIND_STEP, 1'b1, 24'sd300, 24'sd100);
        random_steps(80);
        drain_results();

        // Full gains, empty band, top limit
        program_regs('1, '1, '1, '0, '1);
        random_steps(80);
        drain_results();

        // Zero gains, widest band, zero limit
        program_regs('0, '0, '0, '1, '0);
        random_steps(50);
        drain_results();

        // Moderate gains, short settle limit
        program_regs(24'd65536, 24'd300, 24'd20000, 16'd200, 16'd3);
        random_steps(80);
        drain_results();

        // Back-to-back near-goal run across the settle limit
        burst_mode = 1'b1;
        program_regs(24'd39322, '0, '0, '1, 16'd20);
        hammer(40, 1'b1);
        drain_results();

        // Push both integral sums hard in opposite directions, back off, then clear
        program_regs('0, 24'd1, '0, 16'd45, 16'd30);
        hammer(40, 1'b0);
        send_step(KIND_STEP, 1'b0, POS_MIN, POS_MAX);
        send_step(KIND_STEP, 1'b1, POS_MIN, POS_MAX);
        send_step(KIND_STEP, 1'b0, POS_MIN, POS_MAX);
        send_step(KIND_CLEAR, 1'b0, 24'sd0, 24'sd0);
        send_step(KIND_STEP, 1'b0, 24'sd100, 24'sd0);
        send_step(KIND_STEP, 1'b1, 24'sd0, 24'sd100);
        burst_mode = 1'b0;
        drain_results();

        // Back to power-on settings
        program_regs(24'd39322, '0, '0, 16'd45, 16'd30);
        random_steps(50);
        drain_results();

        if (fail_count == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
